[rtl/sbc_pkg.sv]
// sbc_pkg: shared types and constants for the sphere versus box collide and resolve unit
// no dependencies; used by sbc_isqrt, sbc_div and sphere_box_collide_resolve_unit
`timescale 1ns / 1ps
`default_nettype none

package sbc_pkg;

    localparam int COORD_W     = 32;
    localparam int RADIUS_W    = 31;
    localparam int RAD_W       = 62;
    localparam int ROOT_W      = 31;
    localparam int NUM_W       = 63;
    localparam int QUO_W       = 32;
    localparam int SQRT_STAGES = 31;
    localparam int DIV_STAGES  = 32;
    localparam int IN_DATA_W   = 320;
    localparam int OUT_DATA_W  = 104;

    typedef logic [2:0][COORD_W-1:0] vec3_t;

    typedef struct packed {
        vec3_t                   closest;
        vec3_t                   center;
        logic [2:0]              neg;
        logic [2:0][RAD_W-1:0]   prod;
        logic                    touching;
        logic                    pushed;
        logic                    center_in;
    } sbc_side_t;

endpackage

`default_nettype wire

[rtl/sphere_box_collide_resolve_unit.sv]
// sphere_box_collide_resolve_unit: sphere against axis-aligned box test and push-out
// one word accepted every cycle unless the pipeline holds for the output
// depth set by 3 front stages, 31 square-root stages, 1 stage, 32 divider stages, output
// the whole pipeline holds while a finished word waits at the output
// rst_n asynchronous active low clears all valid bits; data registers are not reset
`timescale 1ns / 1ps
`default_nettype none

module sphere_box_collide_resolve_unit
    import sbc_pkg::*;
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   s_tvalid,
    output logic                        s_tready,
    // box_min_x, box_min_y, box_min_z, box_max_x, box_max_y, box_max_z,
    // sphere_center_x, sphere_center_y, sphere_center_z, sphere_radius, zero pad
    input  wire logic [IN_DATA_W-1:0]   s_tdata,
    output logic                        m_tvalid,
    input  wire logic                   m_tready,
    // touching, pushed, center_inside, new_center_x, new_center_y, new_center_z, zero pad
    output logic [OUT_DATA_W-1:0]       m_tdata
);

    logic en;

    // stage 1: clamp and offset
    logic                         v1_reg;
    vec3_t                        closest1_reg;
    vec3_t                        center1_reg;
    logic [2:0]                   neg1_reg;
    logic [2:0][RADIUS_W-1:0]     ad1_reg;
    logic                         far1_reg;
    logic                         inside1_reg;
    logic [RADIUS_W-1:0]          r1_reg;

    vec3_t                        closest1_next;
    vec3_t                        center1_next;
    logic [2:0]                   neg1_next;
    logic [2:0][RADIUS_W-1:0]     ad1_next;
    logic [2:0]                   far_ax;
    logic [2:0]                   zero_ax;
    logic [RADIUS_W-1:0]          r_in;

    assign r_in = s_tdata[9*COORD_W +: RADIUS_W];

    for (genvar a = 0; a < 3; a++) begin : g_clamp
        logic signed [COORD_W-1:0] lo;
        logic signed [COORD_W-1:0] hi;
        logic signed [COORD_W-1:0] c;
        logic signed [COORD_W-1:0] t;
        logic signed [COORD_W-1:0] cl;
        logic signed [COORD_W:0]   d;
        logic        [COORD_W:0]   ad;

        assign lo = s_tdata[a*COORD_W +: COORD_W];
        assign hi = s_tdata[(3+a)*COORD_W +: COORD_W];
        assign c  = s_tdata[(6+a)*COORD_W +: COORD_W];
        assign t  = (c < hi) ? c : hi;
        assign cl = (lo > t) ? lo : t;
        assign d  = {c[COORD_W-1], c} - {cl[COORD_W-1], cl};
        assign ad = d[COORD_W] ? (COORD_W+1)'(-d) : d;

        assign closest1_next[a] = cl;
        assign center1_next[a]  = c;
        assign neg1_next[a]     = d[COORD_W];
        assign ad1_next[a]      = ad[RADIUS_W-1:0];
        assign far_ax[a]        = (ad > (COORD_W+1)'(r_in));
        assign zero_ax[a]       = (ad == '0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            closest1_reg <= closest1_next;
            center1_reg  <= center1_next;
            neg1_reg     <= neg1_next;
            ad1_reg      <= ad1_next;
            far1_reg     <= |far_ax;
            inside1_reg  <= &zero_ax;
            r1_reg       <= r_in;
        end
    end

    // stage 2: squares and products
    logic                         v2_reg;
    vec3_t                        closest2_reg;
    vec3_t                        center2_reg;
    logic [2:0]                   neg2_reg;
    logic [2:0][RAD_W-1:0]        sq2_reg;
    logic [2:0][RAD_W-1:0]        prod2_reg;
    logic [RAD_W-1:0]             r2_reg;
    logic                         far2_reg;
    logic                         inside2_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v2_reg <= 1'b0;
        end
        else if (en)
        begin
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            closest2_reg <= closest1_reg;
            center2_reg  <= center1_reg;
            neg2_reg     <= neg1_reg;
            for (int a = 0; a < 3; a++)
            begin
                sq2_reg[a]   <= RAD_W'(ad1_reg[a]) * RAD_W'(ad1_reg[a]);
                prod2_reg[a] <= RAD_W'(ad1_reg[a]) * RAD_W'(r1_reg);
            end
            r2_reg      <= RAD_W'(r1_reg) * RAD_W'(r1_reg);
            far2_reg    <= far1_reg;
            inside2_reg <= inside1_reg;
        end
    end

    // stage 3: distance squared against radius squared
    logic                         v3_reg;
    sbc_side_t                    side3_reg;
    logic [RAD_W-1:0]             rad3_reg;
    logic [RAD_W+1:0]             sum3;
    sbc_side_t                    side3_next;

    always_comb
    begin
        sum3 = (RAD_W+2)'(sq2_reg[0]) + (RAD_W+2)'(sq2_reg[1]) + (RAD_W+2)'(sq2_reg[2]);
        side3_next.closest   = closest2_reg;
        side3_next.center    = center2_reg;
        side3_next.neg       = neg2_reg;
        side3_next.prod      = prod2_reg;
        side3_next.touching  = !far2_reg && (sum3 <= (RAD_W+2)'(r2_reg));
        side3_next.pushed    = !far2_reg && !inside2_reg && (sum3 < (RAD_W+2)'(r2_reg));
        side3_next.center_in = inside2_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v3_reg <= 1'b0;
        end
        else if (en)
        begin
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            side3_reg <= side3_next;
            rad3_reg  <= sum3[RAD_W-1:0];
        end
    end

    // square root
    logic              sq_valid;
    sbc_side_t         sq_side;
    logic [ROOT_W-1:0] sq_root;

    sbc_isqrt u_isqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_valid (v3_reg),
        .in_side  (side3_reg),
        .radicand (rad3_reg),
        .out_valid(sq_valid),
        .out_side (sq_side),
        .root     (sq_root)
    );

    // rounding term and divisor
    logic                  v4_reg;
    sbc_side_t             side4_reg;
    logic [ROOT_W-1:0]     len4_reg;
    logic [2:0][NUM_W-1:0] num4_reg;
    logic [ROOT_W-1:0]     len_safe;

    assign len_safe = (sq_root == '0) ? ROOT_W'(1) : sq_root;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v4_reg <= 1'b0;
        end
        else if (en)
        begin
            v4_reg <= sq_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            side4_reg <= sq_side;
            len4_reg  <= len_safe;
            for (int a = 0; a < 3; a++)
            begin
                num4_reg[a] <= NUM_W'(sq_side.prod[a]) + NUM_W'(sq_root >> 1);
            end
        end
    end

    // division
    logic                  dv_valid;
    sbc_side_t             dv_side;
    logic [2:0][QUO_W-1:0] dv_quot;

    sbc_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_valid (v4_reg),
        .in_side  (side4_reg),
        .divisor  (len4_reg),
        .num      (num4_reg),
        .out_valid(dv_valid),
        .out_side (dv_side),
        .quot     (dv_quot)
    );

    // push out, saturate and output register
    vec3_t new_center;

    for (genvar a = 0; a < 3; a++) begin : g_push
        logic [COORD_W+1:0] cl_ext;
        logic [COORD_W+1:0] mag_ext;
        logic [COORD_W+1:0] s;
        logic [COORD_W-1:0] sat;

        assign cl_ext  = {{2{dv_side.closest[a][COORD_W-1]}}, dv_side.closest[a]};
        assign mag_ext = {2'b00, dv_quot[a]};
        assign s       = dv_side.neg[a] ? (cl_ext - mag_ext) : (cl_ext + mag_ext);

        always_comb
        begin
            if (!s[COORD_W+1] && (s[COORD_W:COORD_W-1] != 2'b00))
            begin
                sat = {1'b0, {(COORD_W-1){1'b1}}};
            end
            else if (s[COORD_W+1] && (s[COORD_W:COORD_W-1] != 2'b11))
            begin
                sat = {1'b1, {(COORD_W-1){1'b0}}};
            end
            else
            begin
                sat = s[COORD_W-1:0];
            end
        end

        assign new_center[a] = dv_side.pushed ? sat : dv_side.center[a];
    end

    logic                  out_valid_reg;
    logic                  touching_reg;
    logic                  pushed_reg;
    logic                  inside_reg;
    vec3_t                 new_center_reg;

    assign en = !out_valid_reg || m_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            out_valid_reg <= dv_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            touching_reg   <= dv_side.touching;
            pushed_reg     <= dv_side.pushed;
            inside_reg     <= dv_side.center_in;
            new_center_reg <= new_center;
        end
    end

    assign s_tready = en;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {5'b00000, new_center_reg[2], new_center_reg[1], new_center_reg[0],
                       inside_reg, pushed_reg, touching_reg};

`ifndef SYNTHESIS
    a_pushed_touching: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && pushed_reg |-> touching_reg)
        else $error("pushed word not marked touching");
    a_pushed_outside: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && pushed_reg |-> !inside_reg)
        else $error("pushed word marked inside");
    a_inside_touching: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && inside_reg |-> touching_reg)
        else $error("inside word not marked touching");
    a_stall_holds_pipe: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !m_tready |=> $stable(v4_reg) && $stable(v3_reg))
        else $error("pipeline moved during output stall");
`endif

endmodule

`default_nettype wire

[rtl/sbc_isqrt.sv]
// sbc_isqrt: pipelined integer square root, one result bit per stage
// depends on sbc_pkg; side data travels alongside each word
`timescale 1ns / 1ps
`default_nettype none

module sbc_isqrt
    import sbc_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              en,
    input  wire logic              in_valid,
    input  wire sbc_side_t         in_side,
    input  wire logic [RAD_W-1:0]  radicand,
    output logic                   out_valid,
    output sbc_side_t              out_side,
    output logic [ROOT_W-1:0]      root
);

    logic [SQRT_STAGES-1:0] valid_reg;
    logic [NUM_W-1:0]       n_reg   [SQRT_STAGES];
    logic [NUM_W-1:0]       res_reg [SQRT_STAGES];
    sbc_side_t              side_reg[SQRT_STAGES];

    for (genvar i = 0; i < SQRT_STAGES; i++) begin : g_stage
        localparam logic [NUM_W-1:0] BIT = NUM_W'(1) << (2 * (SQRT_STAGES - 1 - i));
        logic [NUM_W-1:0] n_in;
        logic [NUM_W-1:0] res_in;
        logic [NUM_W-1:0] trial;
        logic [NUM_W-1:0] n_next;
        logic [NUM_W-1:0] res_next;
        logic             v_in;
        logic             ge;
        sbc_side_t        s_in;

        if (i == 0) begin : g_first
            assign n_in   = {1'b0, radicand};
            assign res_in = '0;
            assign v_in   = in_valid;
            assign s_in   = in_side;
        end else begin : g_rest
            assign n_in   = n_reg[i-1];
            assign res_in = res_reg[i-1];
            assign v_in   = valid_reg[i-1];
            assign s_in   = side_reg[i-1];
        end

        always_comb
        begin
            trial    = res_in + BIT;
            ge       = (n_in >= trial);
            n_next   = ge ? (n_in - trial) : n_in;
            res_next = ge ? ((res_in >> 1) + BIT) : (res_in >> 1);
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                valid_reg[i] <= 1'b0;
            end
            else if (en)
            begin
                valid_reg[i] <= v_in;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                n_reg[i]    <= n_next;
                res_reg[i]  <= res_next;
                side_reg[i] <= s_in;
            end
        end
    end

    assign out_valid = valid_reg[SQRT_STAGES-1];
    assign out_side  = side_reg[SQRT_STAGES-1];
    assign root      = res_reg[SQRT_STAGES-1][ROOT_W-1:0];

endmodule

`default_nettype wire

[rtl/sbc_div.sv]
// sbc_div: pipelined restoring divider, three dividends over one shared divisor
// depends on sbc_pkg; one quotient bit per stage, side data travels alongside
`timescale 1ns / 1ps
`default_nettype none

module sbc_div
    import sbc_pkg::*;
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   en,
    input  wire logic                   in_valid,
    input  wire sbc_side_t              in_side,
    input  wire logic [ROOT_W-1:0]      divisor,
    input  wire logic [2:0][NUM_W-1:0]  num,
    output logic                        out_valid,
    output sbc_side_t                   out_side,
    output logic [2:0][QUO_W-1:0]       quot
);

    logic [DIV_STAGES-1:0]   valid_reg;
    logic [2:0][NUM_W-1:0]   rem_reg [DIV_STAGES];
    logic [2:0][QUO_W-1:0]   q_reg   [DIV_STAGES];
    logic [ROOT_W-1:0]       dvs_reg [DIV_STAGES];
    sbc_side_t               side_reg[DIV_STAGES];

    for (genvar i = 0; i < DIV_STAGES; i++) begin : g_stage
        localparam int SHIFT = DIV_STAGES - 1 - i;
        logic [2:0][NUM_W-1:0] rem_in;
        logic [2:0][QUO_W-1:0] q_in;
        logic [2:0][NUM_W-1:0] rem_next;
        logic [2:0][QUO_W-1:0] q_next;
        logic [ROOT_W-1:0]     dvs_in;
        logic [NUM_W-1:0]      dvs_sh;
        logic                  v_in;
        sbc_side_t             s_in;

        if (i == 0) begin : g_first
            assign rem_in = num;
            assign q_in   = '0;
            assign dvs_in = divisor;
            assign v_in   = in_valid;
            assign s_in   = in_side;
        end else begin : g_rest
            assign rem_in = rem_reg[i-1];
            assign q_in   = q_reg[i-1];
            assign dvs_in = dvs_reg[i-1];
            assign v_in   = valid_reg[i-1];
            assign s_in   = side_reg[i-1];
        end

        assign dvs_sh = NUM_W'(dvs_in) << SHIFT;

        for (genvar a = 0; a < 3; a++) begin : g_axis
            logic ge;
            assign ge          = (rem_in[a] >= dvs_sh);
            assign rem_next[a] = ge ? (rem_in[a] - dvs_sh) : rem_in[a];
            assign q_next[a]   = {q_in[a][QUO_W-2:0], ge};
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                valid_reg[i] <= 1'b0;
            end
            else if (en)
            begin
                valid_reg[i] <= v_in;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[i]  <= rem_next;
                q_reg[i]    <= q_next;
                dvs_reg[i]  <= dvs_in;
                side_reg[i] <= s_in;
            end
        end
    end

    assign out_valid = valid_reg[DIV_STAGES-1];
    assign out_side  = side_reg[DIV_STAGES-1];
    assign quot      = q_reg[DIV_STAGES-1];

endmodule

`default_nettype wire
